/* rtl/core/wev_pkg.sv */
// Shared types and constants of the weighted ensemble vote block.
`default_nettype none

package wev_pkg;

	// Method store depth and index widths
	localparam int MAX_METHODS = 16;
	localparam int METH_BITS   = 4;
	localparam int CNT_BITS    = 5;

	// Weight modes (code 3 falls back to proportional)
	localparam logic [1:0] WM_PROP  = 2'd0;
	localparam logic [1:0] WM_EQUAL = 2'd1;
	localparam logic [1:0] WM_BEST  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_WEIGHT_MODE  = 2'd0;
	localparam logic [1:0] CFG_METHOD_COUNT = 2'd1;

	// Input item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_VOTE = 1'b1;

	// Top level sequencer
	typedef enum logic [3:0] {
		T_IDLE  = 4'b0001,
		T_ERR   = 4'b0010,
		T_BSCAN = 4'b0100,
		T_TALLY = 4'b1000
	} top_state_t;

	// Tally sequencer
	typedef enum logic [2:0] {
		Y_IDLE = 3'b001,
		Y_SRCH = 3'b010,
		Y_MAX  = 3'b100
	} tly_state_t;

	// Request from the top level to the tally
	typedef struct packed {
		logic go;
		logic last;
	} tly_ctl_t;

	// Status back from the tally
	typedef struct packed {
		logic done;
	} tly_sts_t;

endpackage

`default_nettype wire

/* rtl/core/wev_tally.sv */
// Tally memory of distinct labels with summed weights, search, append and final max scan.
`default_nettype none

module wev_tally #(
	parameter int LABEL_BITS = 8,
	parameter int WB         = 21
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wev_pkg::tly_ctl_t      ctl,
	input  wire [LABEL_BITS-1:0]   label,
	input  wire [WB-1:0]           weight,
	output wev_pkg::tly_sts_t      sts,
	output logic                   res_vld,
	output logic [LABEL_BITS-1:0]  res_label
);

	localparam int MB = wev_pkg::METH_BITS;
	localparam int CB = wev_pkg::CNT_BITS;
	localparam int DW = LABEL_BITS + WB;

	wev_pkg::tly_state_t state_q, state_d;
	logic [CB-1:0]         cnt_q, cnt_d;
	logic [CB-1:0]         used_q, used_d;
	logic [WB-1:0]         best_w_q, best_w_d;
	logic [LABEL_BITS-1:0] best_lbl_q, best_lbl_d;
	logic                  res_vld_q, res_vld_d;
	logic [LABEL_BITS-1:0] res_lbl_q, res_lbl_d;

	// Memory ports
	logic [DW-1:0] tal_mem [wev_pkg::MAX_METHODS];
	logic [DW-1:0] rd_q;
	logic          wr_en;
	logic [MB-1:0] wr_addr;
	logic [DW-1:0] wr_data;

	logic [LABEL_BITS-1:0] rd_lbl;
	logic [WB-1:0]         rd_w;
	logic [WB:0]           sum;
	logic [WB-1:0]         sum_sat;
	logic [CB-1:0]         prev;
	logic                  done;

	assign rd_lbl  = rd_q[DW-1:WB];
	assign rd_w    = rd_q[WB-1:0];
	assign sum     = {1'b0, rd_w} + {1'b0, weight};
	assign sum_sat = sum[WB] ? {WB{1'b1}} : sum[WB-1:0];
	assign prev    = cnt_q - CB'(1);

	// Synchronous memory, one read and one write a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tal_mem[wr_addr] <= wr_data;
		end
		rd_q <= tal_mem[cnt_q[MB-1:0]];
	end

	// Sequencer: entry cnt-1 is checked while entry cnt is read
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		used_d     = used_q;
		best_w_d   = best_w_q;
		best_lbl_d = best_lbl_q;
		res_vld_d  = 1'b0;
		res_lbl_d  = res_lbl_q;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = {label, weight};
		done       = 1'b0;
		unique case (state_q)
			wev_pkg::Y_IDLE: begin
				cnt_d = '0;
				if (ctl.go) begin
					state_d = wev_pkg::Y_SRCH;
				end
			end
			wev_pkg::Y_SRCH: begin
				priority if (cnt_q != '0 && rd_lbl == label) begin
					// label already present: saturating add
					wr_en   = 1'b1;
					wr_addr = prev[MB-1:0];
					wr_data = {label, sum_sat};
				end else if (cnt_q == used_q) begin
					// new label, dropped when the tally is full
					if (used_q < CB'(wev_pkg::MAX_METHODS)) begin
						wr_en   = 1'b1;
						wr_addr = used_q[MB-1:0];
						used_d  = used_q + CB'(1);
					end
				end else begin
					cnt_d = cnt_q + CB'(1);
				end
				if (wr_en || cnt_q == used_q) begin
					cnt_d = '0;
					if (ctl.last) begin
						state_d = wev_pkg::Y_MAX;
					end else begin
						state_d = wev_pkg::Y_IDLE;
						done    = 1'b1;
					end
				end
			end
			wev_pkg::Y_MAX: begin
				if (cnt_q != '0 && (cnt_q == CB'(1) || rd_w > best_w_q)) begin
					best_w_d   = rd_w;
					best_lbl_d = rd_lbl;
				end
				if (cnt_q == used_q) begin
					res_vld_d = 1'b1;
					res_lbl_d = best_lbl_d;
					used_d    = '0;
					cnt_d     = '0;
					state_d   = wev_pkg::Y_IDLE;
					done      = 1'b1;
				end else begin
					cnt_d = cnt_q + CB'(1);
				end
			end
			default: begin
				state_d = wev_pkg::Y_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wev_pkg::Y_IDLE;
			cnt_q     <= '0;
			used_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			used_q    <= used_d;
			res_vld_q <= res_vld_d;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		best_w_q   <= best_w_d;
		best_lbl_q <= best_lbl_d;
		res_lbl_q  <= res_lbl_d;
	end

	assign sts.done  = done;
	assign res_vld   = res_vld_q;
	assign res_label = res_lbl_q;

endmodule

`default_nettype wire

/* rtl/core/weighted_ensemble_vote.sv */
// Top level of the weighted ensemble vote: configuration, error store and weight sequencer.
//
//  channel   signals                                          handshake
//  -------   ----------------------------------------------   ---------------------------
//  item in   mode method_index error_value class_label        start && !busy
//            last_of_example
//  result    winning_label                                    done, one cycle, no stall
//  config    cfg_we cfg_index cfg_data                        cfg_we
//
// A load item does not make the block busy. A vote goes straight to the tally in EQUAL
// mode, reads its error first in PROP mode, or in BEST mode scans the error store over the
// active count (one read a cycle); then the tally searches its used entries, and on the
// last vote runs a max scan over them; used <= 16.
// These steps are paced by the single read port of the error and tally memories.
// Result appears in the cycle after the tally finishes; the receiver cannot stall it.
// Reset (arst_n low) empties the tally and sets PROP mode with 16 methods.
`default_nettype none

module weighted_ensemble_vote #(
	parameter int LABEL_BITS      = 8,
	parameter int ERROR_FRAC_BITS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire                        mode,
	input  wire [3:0]                  method_index,
	input  wire [ERROR_FRAC_BITS:0]    error_value,
	input  wire [LABEL_BITS-1:0]       class_label,
	input  wire                        last_of_example,
	output logic                       done,
	output logic [LABEL_BITS-1:0]      winning_label,
	input  wire                        cfg_we,
	input  wire [1:0]                  cfg_index,
	input  wire [4:0]                  cfg_data
);

	localparam int EB = ERROR_FRAC_BITS + 1;
	localparam int WB = ERROR_FRAC_BITS + 5;
	localparam int MB = wev_pkg::METH_BITS;
	localparam int CB = wev_pkg::CNT_BITS;

	// Configuration registers
	logic [1:0]    wmode_q;
	logic [CB-1:0] mcount_q;
	logic [CB-1:0] n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmode_q  <= wev_pkg::WM_PROP;
			mcount_q <= CB'(wev_pkg::MAX_METHODS);
		end else if (cfg_we) begin
			if (cfg_index == wev_pkg::CFG_WEIGHT_MODE) begin
				wmode_q <= cfg_data[1:0];
			end else if (cfg_index == wev_pkg::CFG_METHOD_COUNT) begin
				mcount_q <= cfg_data;
			end
		end
	end

	// Active method count, clamped to 1..MAX_METHODS
	always_comb begin
		priority if (mcount_q == '0) begin
			n_act = CB'(1);
		end else if (mcount_q > CB'(wev_pkg::MAX_METHODS)) begin
			n_act = CB'(wev_pkg::MAX_METHODS);
		end else begin
			n_act = mcount_q;
		end
	end

	wev_pkg::top_state_t state_q, state_d;
	logic [CB-1:0]         cnt_q, cnt_d;
	logic                  go_q, go_d;
	logic [MB-1:0]         idx_q;
	logic [LABEL_BITS-1:0] lbl_q;
	logic                  last_q;
	logic [EB-1:0]         best_e_q, best_e_d;
	logic [MB-1:0]         best_i_q, best_i_d;
	logic [WB-1:0]         wgt_q, wgt_d;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != wev_pkg::T_IDLE);

	// Error store: one write and one registered read a cycle
	logic [EB-1:0] err_mem [wev_pkg::MAX_METHODS];
	logic [EB-1:0] err_rd_q;
	logic [MB-1:0] err_rd_addr;

	assign err_rd_addr = (state_q == wev_pkg::T_BSCAN) ? cnt_q[MB-1:0] : method_index;

	always_ff @(posedge clk) begin
		if (accept && mode == wev_pkg::MODE_LOAD) begin
			err_mem[method_index] <= error_value;
		end
		err_rd_q <= err_mem[err_rd_addr];
	end

	// Accuracy = one - error, floored at zero
	logic [WB-1:0] acc;
	logic [CB-1:0] prev;
	assign acc  = err_rd_q[EB-1] ? '0 : ((WB'(1) << ERROR_FRAC_BITS) - WB'(err_rd_q));
	assign prev = cnt_q - CB'(1);

	// Tally interface
	wev_pkg::tly_ctl_t ctl;
	wev_pkg::tly_sts_t sts;
	assign ctl.go   = go_q;
	assign ctl.last = last_q;

	// Weight sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		go_d     = 1'b0;
		best_e_d = best_e_q;
		best_i_d = best_i_q;
		wgt_d    = wgt_q;
		unique case (state_q)
			wev_pkg::T_IDLE: begin
				cnt_d = '0;
				if (accept && mode == wev_pkg::MODE_VOTE) begin
					if (wmode_q == wev_pkg::WM_EQUAL) begin
						wgt_d   = WB'(1);
						go_d    = 1'b1;
						state_d = wev_pkg::T_TALLY;
					end else if (wmode_q == wev_pkg::WM_BEST) begin
						state_d = wev_pkg::T_BSCAN;
					end else begin
						state_d = wev_pkg::T_ERR;
					end
				end
			end
			wev_pkg::T_ERR: begin
				wgt_d   = acc;
				go_d    = 1'b1;
				state_d = wev_pkg::T_TALLY;
			end
			wev_pkg::T_BSCAN: begin
				// least error, lowest index wins ties
				if (cnt_q != '0 && (cnt_q == CB'(1) || err_rd_q < best_e_q)) begin
					best_e_d = err_rd_q;
					best_i_d = prev[MB-1:0];
				end
				if (cnt_q == n_act) begin
					wgt_d   = (idx_q == best_i_d) ? WB'(1) : '0;
					go_d    = 1'b1;
					state_d = wev_pkg::T_TALLY;
				end else begin
					cnt_d = cnt_q + CB'(1);
				end
			end
			wev_pkg::T_TALLY: begin
				if (sts.done) begin
					state_d = wev_pkg::T_IDLE;
				end
			end
			default: begin
				state_d = wev_pkg::T_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wev_pkg::T_IDLE;
			cnt_q   <= '0;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			go_q    <= go_d;
		end
	end

	// Item payload and scan results
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= method_index;
			lbl_q  <= class_label;
			last_q <= last_of_example;
		end
		best_e_q <= best_e_d;
		best_i_q <= best_i_d;
		wgt_q    <= wgt_d;
	end

	wev_tally #(
		.LABEL_BITS (LABEL_BITS),
		.WB         (WB)
	) u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.label     (lbl_q),
		.weight    (wgt_q),
		.sts       (sts),
		.res_vld   (done),
		.res_label (winning_label)
	);

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for weighted_ensemble_vote: directed and random items, tally mirror.
`default_nettype none

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	// idle cycles required before a register write or a hold is released
	localparam int SETTLE      = 80;
	localparam int PHASE_ITEMS = 34;
	localparam int MAX_GAP     = 18;

	localparam logic [1:0]  WM_SPARE   = 2'd3;
	localparam logic [16:0] ERR_ONE    = 17'h10000;
	localparam logic [16:0] ERR_TOP    = 17'h1FFFF;
	localparam logic [20:0] WEIGHT_SAT = 21'h1FFFFF;

	typedef enum logic [1:0] {
		PEND_ITEM,
		PEND_CFG,
		PEND_HOLD
	} pend_kind_t;

	typedef struct packed {
		pend_kind_t  kind;
		logic        mode;
		logic [3:0]  midx;
		logic [16:0] err;
		logic [7:0]  label;
		logic        last;
		logic [1:0]  reg_index;
		logic [4:0]  reg_value;
	} pend_t;

	// DUT pins
	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        start           = 1'b0;
	logic        mode            = 1'b0;
	logic [3:0]  method_index    = 4'd0;
	logic [16:0] error_value     = 17'd0;
	logic [7:0]  class_label     = 8'd0;
	logic        last_of_example = 1'b0;
	logic        cfg_we          = 1'b0;
	logic [1:0]  cfg_index       = 2'd0;
	logic [4:0]  cfg_data        = 5'd0;
	wire         busy;
	wire         done;
	wire  [7:0]  winning_label;

	// Stimulus and expected winners
	pend_t      pending_items[$];
	logic [7:0] winner_q[$];

	// Mirror of the block state
	logic [1:0]  wm_mirror = wev_pkg::WM_PROP;
	logic [4:0]  mc_mirror = 5'd16;
	logic [16:0] err_mirror [wev_pkg::MAX_METHODS];
	logic [7:0]  tally_lab  [wev_pkg::MAX_METHODS];
	logic [20:0] tally_wt   [wev_pkg::MAX_METHODS];
	int          tally_used = 0;

	int cycle_count  = 0;
	int fail_count   = 0;
	int queued_items = 0;
	int loads_done   = 0;
	int votes_done   = 0;
	int results_seen = 0;
	int cfg_writes   = 0;

	weighted_ensemble_vote dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.method_index   (method_index),
		.error_value    (error_value),
		.class_label    (class_label),
		.last_of_example(last_of_example),
		.done           (done),
		.winning_label  (winning_label),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic push_item(input logic m, input logic [3:0] idx, input logic [16:0] e,
			input logic [7:0] lb, input logic lst);
		pend_t p;
		p = '0;
		p.kind = PEND_ITEM;
		p.mode = m;
		p.midx = idx;
		p.err = e;
		p.label = lb;
		p.last = lst;
		pending_items = {pending_items, p};
		queued_items++;
	endtask

	task automatic push_cfg(input logic [1:0] idx, input logic [4:0] val);
		pend_t p;
		p = '0;
		p.kind = PEND_CFG;
		p.reg_index = idx;
		p.reg_value = val;
		pending_items = {pending_items, p};
	endtask

	task automatic push_hold();
		pend_t p;
		p = '0;
		p.kind = PEND_HOLD;
		pending_items = {pending_items, p};
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		$display("MISMATCH cycle %0d: %s (expected %0d, got %0d)", cycle_count, what, want, got);
		fail_count++;
	endtask

	// Weight of one vote under the mirrored mode
	function automatic logic [20:0] vote_weight(input logic [3:0] idx);
		int n;
		int best;
		int i;
		if (wm_mirror == wev_pkg::WM_EQUAL)
			return 21'd1;
		if (wm_mirror == wev_pkg::WM_BEST) begin
			n = (mc_mirror == 0) ? 1 :
				((mc_mirror > wev_pkg::MAX_METHODS) ? wev_pkg::MAX_METHODS : int'(mc_mirror));
			best = 0;
			for (i = 1; i < n; i++)
				if (err_mirror[i] < err_mirror[best])
					best = i;
			return (idx == best) ? 21'd1 : 21'd0;
		end
		// proportional, also for the spare code
		if (err_mirror[idx] >= ERR_ONE)
			return 21'd0;
		return {4'b0, ERR_ONE - err_mirror[idx]};
	endfunction

	// Apply one accepted item to the mirror; queue the winner on a closing vote
	task automatic score_item(input pend_t p);
		logic [20:0] w;
		logic [21:0] sum;
		int j;
		int c;
		bit hit;
		if (p.mode == wev_pkg::MODE_LOAD) begin
			err_mirror[p.midx] = p.err;
			loads_done++;
		end else begin
			votes_done++;
			w = vote_weight(p.midx);
			hit = 1'b0;
			for (j = 0; j < tally_used; j++)
				if (!hit && tally_lab[j] == p.label) begin
					sum = {1'b0, tally_wt[j]} + {1'b0, w};
					tally_wt[j] = (sum > {1'b0, WEIGHT_SAT}) ? WEIGHT_SAT : sum[20:0];
					hit = 1'b1;
				end
			// a new label with no free entry is dropped
			if (!hit && tally_used < wev_pkg::MAX_METHODS) begin
				tally_lab[tally_used] = p.label;
				tally_wt[tally_used] = w;
				tally_used++;
			end
			if (p.last) begin
				c = 0;
				for (j = 1; j < tally_used; j++)
					if (tally_wt[j] > tally_wt[c])
						c = j;
				winner_q = {winner_q, tally_lab[c]};
				tally_used = 0;
			end
		end
	endtask

	// Driver: presents queued items, register writes and holds
	always @(posedge clk) begin : drive_proc
		pend_t cur;
		pend_t head;
		logic  nx_start;
		logic  nx_we;
		int    gap_left;
		int    quiet;
		bit    gapless;
		nx_start = start;
		nx_we = 1'b0;
		if (arst_n) begin
			if (busy || start)
				quiet = 0;
			else
				quiet++;
			if (start && !busy) begin
				score_item(cur);
				nx_start = 1'b0;
				gap_left = gapless ? 0 : $urandom_range(0, MAX_GAP);
				if ($urandom_range(0, 29) == 0)
					gapless = !gapless;
			end
			if (!nx_start) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_items.size() != 0) begin
					head = pending_items[0];
					case (head.kind)
						PEND_ITEM: begin
							cur = head;
							void'(pending_items.pop_front());
							nx_start = 1'b1;
							mode <= head.mode;
							method_index <= head.midx;
							error_value <= head.err;
							class_label <= head.label;
							last_of_example <= head.last;
						end
						PEND_CFG: begin
							if (quiet >= SETTLE && winner_q.size() == 0) begin
								void'(pending_items.pop_front());
								nx_we = 1'b1;
								cfg_index <= head.reg_index;
								cfg_data <= head.reg_value;
								if (head.reg_index == wev_pkg::CFG_WEIGHT_MODE)
									wm_mirror = head.reg_value[1:0];
								else if (head.reg_index == wev_pkg::CFG_METHOD_COUNT)
									mc_mirror = head.reg_value;
								cfg_writes++;
							end
						end
						default: begin
							// sender holds off until every winner is back
							if (quiet >= SETTLE && winner_q.size() == 0)
								void'(pending_items.pop_front());
						end
					endcase
				end
			end
		end
		start <= nx_start;
		cfg_we <= nx_we;
	end

	// Monitor: one winner per done strobe, oldest expectation first
	always @(posedge clk) begin : watch_proc
		logic [7:0] want;
		if (arst_n && done !== 1'b0) begin
			results_seen++;
			if (winner_q.size() == 0)
				report_mismatch("winner with no closing vote pending", 8'd0, winning_label);
			else begin
				want = winner_q.pop_front();
				if (winning_label !== want)
					report_mismatch("winning_label", want, winning_label);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d winners outstanding",
				cycle_count, winner_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stim_proc
		int          ph;
		int          k;
		int          len;
		int          nact;
		int          base;
		int          spread;
		int          mark;
		logic [1:0]  wm;
		logic [4:0]  mc;
		logic [3:0]  vidx;
		logic [16:0] e;

		// Load every method first so no vote reads an unwritten error
		for (k = 0; k < wev_pkg::MAX_METHODS; k++) begin
			vidx = 4'(k);
			case (k)
				0, 9:    e = 17'd0;
				1:       e = ERR_ONE;
				2:       e = ERR_TOP;
				3:       e = ERR_ONE + 17'd1;
				4:       e = 17'd1;
				5:       e = ERR_ONE - 17'd1;
				default: e = 17'($urandom_range(2, 65534));
			endcase
			push_item(wev_pkg::MODE_LOAD, vidx, e, 8'($urandom),
				k == wev_pkg::MAX_METHODS - 1);
		end

		// Reset settings: proportional, 16 methods
		// full-accuracy method beats three zero-accuracy ones
		push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), 8'd255, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd1, 17'($urandom), 8'd0, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd2, 17'($urandom), 8'd0, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd3, 17'($urandom), 8'd0, 1'b1);
		// all weights zero: first label seen wins
		push_item(wev_pkg::MODE_VOTE, 4'd1, 17'($urandom), 8'd3, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd2, 17'($urandom), 8'd5, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd3, 17'($urandom), 8'd5, 1'b1);
		// exact tie resolved to first seen; a load with last set leaves the tally alone
		push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), 8'd7, 1'b0);
		push_item(wev_pkg::MODE_LOAD, 4'd6, 17'h0AAAA, 8'($urandom), 1'b1);
		push_item(wev_pkg::MODE_VOTE, 4'd5, 17'($urandom), 8'd8, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd4, 17'($urandom), 8'd8, 1'b1);
		push_item(wev_pkg::MODE_VOTE, 4'd4, 17'($urandom), 8'd128, 1'b1);

		// Spare mode code acts as proportional; zero count
		push_cfg(wev_pkg::CFG_WEIGHT_MODE, {3'b000, WM_SPARE});
		push_cfg(wev_pkg::CFG_METHOD_COUNT, 5'd0);
		push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), 8'd20, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd4, 17'($urandom), 8'd21, 1'b1);
		// best-only with count zero: only method 0 carries weight
		push_cfg(wev_pkg::CFG_WEIGHT_MODE, {3'b000, wev_pkg::WM_BEST});
		push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), 8'd1, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd1, 17'($urandom), 8'd2, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd2, 17'($urandom), 8'd2, 1'b1);
		// methods 0 and 9 share the least error: lower index wins
		push_cfg(wev_pkg::CFG_METHOD_COUNT, 5'd16);
		push_item(wev_pkg::MODE_VOTE, 4'd9, 17'($urandom), 8'd50, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), 8'd60, 1'b1);

		// Full tally: a seventeenth label is dropped even when it would win
		push_cfg(wev_pkg::CFG_WEIGHT_MODE, {3'b000, wev_pkg::WM_EQUAL});
		for (k = 0; k < 19; k++) begin
			vidx = 4'(k % wev_pkg::MAX_METHODS);
			push_item(wev_pkg::MODE_VOTE, vidx, 17'($urandom),
				8'((k < wev_pkg::MAX_METHODS) ? k : 200), k == 18);
		end

		// Weight saturation: both labels clip, so the first keeps the lead
		push_cfg(wev_pkg::CFG_WEIGHT_MODE, {3'b000, wev_pkg::WM_PROP});
		for (k = 0; k < 65; k++)
			push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), (k < 32) ? 8'd1 : 8'd2,
				k == 64);

		// Every voting method at or above one error
		push_item(wev_pkg::MODE_LOAD, 4'd0, ERR_ONE, 8'($urandom), 1'b0);
		push_item(wev_pkg::MODE_LOAD, 4'd1, ERR_TOP, 8'($urandom), 1'b0);
		push_item(wev_pkg::MODE_LOAD, 4'd2, 17'(ERR_ONE + $urandom_range(1, 65535)),
			8'($urandom), 1'b0);
		push_item(wev_pkg::MODE_LOAD, 4'd3, ERR_ONE, 8'($urandom), 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd0, 17'($urandom), 8'd9, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd1, 17'($urandom), 8'd4, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd2, 17'($urandom), 8'd4, 1'b0);
		push_item(wev_pkg::MODE_VOTE, 4'd3, 17'($urandom), 8'd4, 1'b1);
		push_hold();

		// Random phases, one per register setting
		for (ph = 0; ph < 11; ph++) begin
			case (ph)
				0:       begin wm = wev_pkg::WM_PROP;  mc = 5'd16; end
				1:       begin wm = wev_pkg::WM_EQUAL; mc = 5'd1;  end
				2:       begin wm = wev_pkg::WM_BEST;  mc = 5'd16; end
				3:       begin wm = WM_SPARE;          mc = 5'd5;  end
				4:       begin wm = wev_pkg::WM_BEST;  mc = 5'd0;  end
				5:       begin wm = wev_pkg::WM_EQUAL; mc = 5'd31; end
				6:       begin wm = wev_pkg::WM_PROP;  mc = 5'd1;  end
				7:       begin wm = wev_pkg::WM_BEST;  mc = 5'd17; end
				8:       begin wm = wev_pkg::WM_BEST;  mc = 5'd3;  end
				9:       begin wm = wev_pkg::WM_PROP;  mc = 5'd8;  end
				default: begin wm = wev_pkg::WM_BEST;  mc = 5'd31; end
			endcase
			push_cfg(wev_pkg::CFG_WEIGHT_MODE, {3'b000, wm});
			push_cfg(wev_pkg::CFG_METHOD_COUNT, mc);
			nact = (mc == 0) ? 1 :
				((mc > wev_pkg::MAX_METHODS) ? wev_pkg::MAX_METHODS : int'(mc));
			mark = queued_items;
			while (queued_items - mark < PHASE_ITEMS) begin
				k = $urandom_range(0, 9);
				if (k < 7) begin
					// well-formed example, now and then with extra trailing votes
					len = nact + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
					base = $urandom_range(0, 255);
					case ($urandom_range(0, 3))
						0:       spread = 0;
						1:       spread = 1;
						2:       spread = 3;
						default: spread = 255;
					endcase
					for (k = 0; k < len; k++) begin
						vidx = 4'(k % wev_pkg::MAX_METHODS);
						push_item(wev_pkg::MODE_VOTE, vidx, 17'($urandom),
							8'(base ^ ($urandom & spread)), k == len - 1);
					end
				end else if (k < 9) begin
					case ($urandom_range(0, 3))
						0, 1: e = 17'($urandom_range(0, 65535));
						2:    e = 17'($urandom_range(0, 131071));
						default: begin
							case ($urandom_range(0, 3))
								0:       e = 17'd0;
								1:       e = ERR_ONE;
								2:       e = ERR_ONE - 17'd1;
								default: e = ERR_TOP;
							endcase
						end
					endcase
					push_item(wev_pkg::MODE_LOAD, 4'($urandom), e, 8'($urandom),
						1'($urandom_range(0, 1)));
				end else begin
					// broken sequence: random methods, stray closing flags
					len = $urandom_range(1, 6);
					for (k = 0; k < len; k++)
						push_item(wev_pkg::MODE_VOTE, 4'($urandom), 17'($urandom),
							8'($urandom),
							(k == len - 1) ? 1'($urandom_range(0, 1))
								: ($urandom_range(0, 9) == 0));
				end
				if ($urandom_range(0, 59) == 0)
					push_hold();
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start || winner_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d loads and %0d votes across %0d register writes,", loads_done,
			votes_done, cfg_writes);
		$display("all four weight codes and counts 0/1/3/5/8/16/17/31; %0d winners seen.",
			results_seen);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
